// ===== hw/rtl/crg_pkg.sv =====
`timescale 1ns / 1ps

package crg_pkg;

  // Register map, index = byte address / 8.
  typedef enum logic [2:0] {
    REG_POS_X     = 3'd0,
    REG_POS_Y     = 3'd1,
    REG_POS_Z     = 3'd2,
    REG_VIEW_DIR  = 3'd3,
    REG_UP_VEC    = 3'd4,
    REG_RIGHT_VEC = 3'd5,
    REG_SCALE_H   = 3'd6,
    REG_SCALE_V   = 3'd7
  } reg_idx_t;

  localparam int ADDR_W = 6;

  localparam logic [47:0] VIEW_DIR_RST  = 48'h0000_0000_C000;
  localparam logic [47:0] UP_VEC_RST    = 48'h0000_4000_0000;
  localparam logic [47:0] RIGHT_VEC_RST = 48'h4000_0000_0000;
  localparam logic [23:0] SCALE_RST     = 24'h01_0000;

  // Datapath widths.
  localparam int AH_W   = 42;  // coordinate times scale
  localparam int SUM_W  = 60;  // exact component sum, 46 fraction bits
  localparam int MAG_W  = 59;  // component magnitude
  localparam int POS_W  = 6;   // leading-one position in a magnitude
  localparam int NRM_W  = 30;  // normalized magnitude, top in [2^29, 2^30)
  localparam int SQ_W   = 62;  // sum of squares
  localparam int ROOT_W = 31;  // bits of the integer square root
  localparam int REM_W  = 33;  // square root remainder
  localparam int NUM_W  = 46;  // dividend of the final division
  localparam int QUO_W  = 15;  // quotient bits, result at most 16384

  // Cycles from an accepted start to the done strobe.
  localparam int LATENCY = 7 + ROOT_W + 1 + QUO_W + 1;

endpackage

// ===== hw/rtl/camera_ray_generator_top.sv =====
`timescale 1ns / 1ps
// An accepted word runs stages 1-6, square root, divide, then output register.
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// The depth is set by the 31 one-bit square root stages and 15 divide stages.
// Reset (rst, synchronous) clears all valid bits and done and restores the
// camera registers to their defaults; results are never held off here.

module camera_ray_generator_top
  import crg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [15:0]         u,
  input  logic [15:0]         v,
  output logic                done,
  output logic signed [15:0]  ray_dx,
  output logic signed [15:0]  ray_dy,
  output logic signed [15:0]  ray_dz,
  output logic signed [31:0]  origin_x,
  output logic signed [31:0]  origin_y,
  output logic signed [31:0]  origin_z,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);

  // Camera registers.
  logic [31:0] pos_x, pos_y, pos_z;
  logic [47:0] view_dir, up_vec, right_vec;
  logic [23:0] scale_h, scale_v;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x     <= '0;
      pos_y     <= '0;
      pos_z     <= '0;
      view_dir  <= VIEW_DIR_RST;
      up_vec    <= UP_VEC_RST;
      right_vec <= RIGHT_VEC_RST;
      scale_h   <= SCALE_RST;
      scale_v   <= SCALE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_POS_X:     pos_x     <= pwdata[31:0];
        REG_POS_Y:     pos_y     <= pwdata[31:0];
        REG_POS_Z:     pos_z     <= pwdata[31:0];
        REG_VIEW_DIR:  view_dir  <= pwdata[47:0];
        REG_UP_VEC:    up_vec    <= pwdata[47:0];
        REG_RIGHT_VEC: right_vec <= pwdata[47:0];
        REG_SCALE_H:   scale_h   <= pwdata[23:0];
        REG_SCALE_V:   scale_v   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (cfg_idx)
      REG_POS_X:     prdata = {32'd0, pos_x};
      REG_POS_Y:     prdata = {32'd0, pos_y};
      REG_POS_Z:     prdata = {32'd0, pos_z};
      REG_VIEW_DIR:  prdata = {16'd0, view_dir};
      REG_UP_VEC:    prdata = {16'd0, up_vec};
      REG_RIGHT_VEC: prdata = {16'd0, right_vec};
      REG_SCALE_H:   prdata = {40'd0, scale_h};
      REG_SCALE_V:   prdata = {40'd0, scale_v};
      default:       prdata = '0;
    endcase
  end

  // Stage 1: screen offsets times the field of view scales.
  logic signed [17:0]     a_c, b_c;
  logic signed [AH_W-1:0] ah_c, bv_c;
  logic signed [AH_W-1:0] ah, bv;
  logic                   vld1;

  assign a_c  = $signed({1'b0, u, 1'b0}) - 18'sd65536;
  assign b_c  = 18'sd65536 - $signed({1'b0, v, 1'b0});
  assign ah_c = AH_W'(a_c) * AH_W'($signed({1'b0, scale_h}));
  assign bv_c = AH_W'(b_c) * AH_W'($signed({1'b0, scale_v}));

  always_ff @(posedge clk) begin
    if (rst) vld1 <= 1'b0;
    else     vld1 <= start && !busy;
    ah <= ah_c;
    bv <= bv_c;
  end

  // Stage 2: products with the right and up vectors, one lane per axis.
  logic signed [SUM_W-1:0] prod_r [3];
  logic signed [SUM_W-1:0] prod_u [3];
  logic signed [15:0]      view_l [3];
  logic                    vld2;

  always_ff @(posedge clk) begin
    if (rst) vld2 <= 1'b0;
    else     vld2 <= vld1;
    for (int i = 0; i < 3; i++) begin
      prod_r[i] <= SUM_W'(ah) * SUM_W'($signed(right_vec[47-16*i -: 16]));
      prod_u[i] <= SUM_W'(bv) * SUM_W'($signed(up_vec[47-16*i -: 16]));
      view_l[i] <= $signed(view_dir[47-16*i -: 16]);
    end
  end

  // Stage 3: exact component sums, split into sign and magnitude.
  logic signed [SUM_W-1:0] sum_c [3];
  logic [MAG_W-1:0]        mag3 [3];
  logic [2:0]              neg3;
  logic                    vld3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_c[i] = prod_r[i] + prod_u[i] + (SUM_W'(view_l[i]) <<< 32);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld3 <= 1'b0;
    else     vld3 <= vld2;
    for (int i = 0; i < 3; i++) begin
      neg3[i] <= sum_c[i][SUM_W-1];
      mag3[i] <= sum_c[i][SUM_W-1] ? MAG_W'(-sum_c[i]) : MAG_W'(sum_c[i]);
    end
  end

  // Stage 4: leading-one position of the largest magnitude.
  logic [MAG_W-1:0] mag_or;
  logic [POS_W-1:0] lead_c;
  logic [MAG_W-1:0] mag4 [3];
  logic [2:0]       neg4;
  logic [POS_W-1:0] lead4;
  logic             zero4;
  logic             vld4;

  assign mag_or = mag3[0] | mag3[1] | mag3[2];

  always_comb begin
    lead_c = '0;
    for (int k = 0; k < MAG_W; k++) begin
      if (mag_or[k]) lead_c = POS_W'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld4 <= 1'b0;
    else     vld4 <= vld3;
    mag4  <= mag3;
    neg4  <= neg3;
    lead4 <= lead_c;
    zero4 <= (mag_or == '0);
  end

  // Stage 5: shift all three so the largest lies in [2^29, 2^30).
  logic [NRM_W-1:0] nrm5 [3];
  logic [2:0]       neg5;
  logic             zero5;
  logic             vld5;

  always_ff @(posedge clk) begin
    if (rst) vld5 <= 1'b0;
    else     vld5 <= vld4;
    for (int i = 0; i < 3; i++) begin
      if (lead4 >= POS_W'(NRM_W - 1)) begin
        nrm5[i] <= NRM_W'(mag4[i] >> (lead4 - POS_W'(NRM_W - 1)));
      end else begin
        nrm5[i] <= NRM_W'(mag4[i] << (POS_W'(NRM_W - 1) - lead4));
      end
    end
    neg5  <= neg4;
    zero5 <= zero4;
  end

  // Stage 6: squares.
  logic [2*NRM_W-1:0] sq6 [3];
  logic [NRM_W-1:0]   nrm6 [3];
  logic [2:0]         neg6;
  logic               zero6;
  logic               vld6;

  always_ff @(posedge clk) begin
    if (rst) vld6 <= 1'b0;
    else     vld6 <= vld5;
    for (int i = 0; i < 3; i++) begin
      sq6[i] <= (2*NRM_W)'(nrm5[i]) * (2*NRM_W)'(nrm5[i]);
    end
    nrm6  <= nrm5;
    neg6  <= neg5;
    zero6 <= zero5;
  end

  // Square root pipeline: entry 0 takes the sum of squares, then one root
  // bit per stage, most significant first.
  logic [SQ_W-1:0]   sq_x    [ROOT_W+1];
  logic [REM_W-1:0]  sq_rem  [ROOT_W+1];
  logic [ROOT_W-1:0] sq_root [ROOT_W+1];
  logic [NRM_W-1:0]  sq_m    [ROOT_W+1][3];
  logic [2:0]        sq_neg  [ROOT_W+1];
  logic              sq_zero [ROOT_W+1];
  logic              sq_vld  [ROOT_W+1];
  logic [REM_W-1:0]  rem_n   [ROOT_W];
  logic [ROOT_W-1:0] root_n  [ROOT_W];

  always_comb begin
    logic [REM_W+1:0] rs;
    logic [REM_W+1:0] tt;
    for (int s = 0; s < ROOT_W; s++) begin
      rs = {sq_rem[s], sq_x[s][2*(ROOT_W-1-s)+1 -: 2]};
      tt = (REM_W+2)'({sq_root[s], 2'b01});
      if (rs >= tt) begin
        rem_n[s]  = REM_W'(rs - tt);
        root_n[s] = {sq_root[s][ROOT_W-2:0], 1'b1};
      end else begin
        rem_n[s]  = REM_W'(rs);
        root_n[s] = {sq_root[s][ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= ROOT_W; s++) sq_vld[s] <= 1'b0;
    end else begin
      sq_vld[0] <= vld6;
      for (int s = 0; s < ROOT_W; s++) sq_vld[s+1] <= sq_vld[s];
    end
    sq_x[0]    <= SQ_W'(sq6[0]) + SQ_W'(sq6[1]) + SQ_W'(sq6[2]);
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
    sq_m[0]    <= nrm6;
    sq_neg[0]  <= neg6;
    sq_zero[0] <= zero6;
    for (int s = 0; s < ROOT_W; s++) begin
      sq_x[s+1]    <= sq_x[s];
      sq_rem[s+1]  <= rem_n[s];
      sq_root[s+1] <= root_n[s];
      sq_m[s+1]    <= sq_m[s];
      sq_neg[s+1]  <= sq_neg[s];
      sq_zero[s+1] <= sq_zero[s];
    end
  end

  // Divide pipeline: entry 0 forms m * 16384 + L/2 for each lane, then one
  // quotient bit per stage, most significant first.
  logic [NUM_W-1:0]  dv_rem  [QUO_W+1][3];
  logic [QUO_W-1:0]  dv_q    [QUO_W+1][3];
  logic [ROOT_W-1:0] dv_len  [QUO_W+1];
  logic [2:0]        dv_neg  [QUO_W+1];
  logic              dv_zero [QUO_W+1];
  logic              dv_vld  [QUO_W+1];
  logic [NUM_W-1:0]  dv_rem_n [QUO_W][3];
  logic [QUO_W-1:0]  dv_q_n   [QUO_W][3];

  always_comb begin
    logic [NUM_W-1:0] dd;
    for (int t = 0; t < QUO_W; t++) begin
      dd = NUM_W'(dv_len[t]) << (QUO_W - 1 - t);
      for (int i = 0; i < 3; i++) begin
        if (dv_rem[t][i] >= dd) begin
          dv_rem_n[t][i] = dv_rem[t][i] - dd;
          dv_q_n[t][i]   = {dv_q[t][i][QUO_W-2:0], 1'b1};
        end else begin
          dv_rem_n[t][i] = dv_rem[t][i];
          dv_q_n[t][i]   = {dv_q[t][i][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t <= QUO_W; t++) dv_vld[t] <= 1'b0;
    end else begin
      dv_vld[0] <= sq_vld[ROOT_W];
      for (int t = 0; t < QUO_W; t++) dv_vld[t+1] <= dv_vld[t];
    end
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] <= (NUM_W'(sq_m[ROOT_W][i]) << 14) +
                      NUM_W'(sq_root[ROOT_W] >> 1);
      dv_q[0][i]   <= '0;
    end
    dv_len[0]  <= sq_root[ROOT_W];
    dv_neg[0]  <= sq_neg[ROOT_W];
    dv_zero[0] <= sq_zero[ROOT_W];
    for (int t = 0; t < QUO_W; t++) begin
      dv_rem[t+1]  <= dv_rem_n[t];
      dv_q[t+1]    <= dv_q_n[t];
      dv_len[t+1]  <= dv_len[t];
      dv_neg[t+1]  <= dv_neg[t];
      dv_zero[t+1] <= dv_zero[t];
    end
  end

  // Output register: apply signs, zero vector when the sum had no length.
  logic [15:0] dir_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero[QUO_W]) begin
        dir_c[i] = '0;
      end else if (dv_neg[QUO_W][i]) begin
        dir_c[i] = 16'd0 - 16'(dv_q[QUO_W][i]);
      end else begin
        dir_c[i] = 16'(dv_q[QUO_W][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv_vld[QUO_W];
    ray_dx   <= $signed(dir_c[0]);
    ray_dy   <= $signed(dir_c[1]);
    ray_dz   <= $signed(dir_c[2]);
    origin_x <= $signed(pos_x);
    origin_y <= $signed(pos_y);
    origin_z <= $signed(pos_z);
  end

endmodule

// ===== hw/rtl/crg_checker.sv =====
`timescale 1ns / 1ps

module crg_checker
  import crg_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [15:0] ray_dx,
  input logic signed [15:0] ray_dy,
  input logic signed [15:0] ray_dz,
  input logic               pready
);

  // Every done word comes from a start exactly one latency earlier.
  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("done without a matching start");

  // Every accepted start produces a done exactly one latency later.
  a_start_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted start produced no done");

  // The pipeline never refuses a word.
  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // A unit direction has no component beyond one in Q2.14.
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (ray_dx >= -16'sd16384) && (ray_dx <= 16'sd16384) &&
             (ray_dy >= -16'sd16384) && (ray_dy <= 16'sd16384) &&
             (ray_dz >= -16'sd16384) && (ray_dz <= 16'sd16384))
    else $error("direction component out of range");

  // The register port never inserts wait states.
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind camera_ray_generator_top crg_checker u_crg_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .ray_dx (ray_dx),
  .ray_dy (ray_dy),
  .ray_dz (ray_dz),
  .pready (pready)
);
